[rtl/lik_pkg.sv]
// Shared types, constants and tables for the two-link leg inverse kinematics block.
// Used by every module under rtl; depends on nothing.
`default_nettype none
package lik_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int SQRT_STEPS    = 24;
   localparam int CW            = 58;
   localparam int ZW            = 34;
   localparam int Q13_PI        = 25736;

   localparam logic signed [ZW-1:0] Q30_PI_HALF = 34'sd1686629713;
   localparam logic [24:0]          DEG_SCALE   = 25'd30039490;

   localparam logic [2:0] CSR_UPPER_LINK = 3'd0;
   localparam logic [2:0] CSR_LOWER_LINK = 3'd1;
   localparam logic [2:0] CSR_HIP_MIN    = 3'd2;
   localparam logic [2:0] CSR_HIP_MAX    = 3'd3;
   localparam logic [2:0] CSR_KNEE_MIN   = 3'd4;
   localparam logic [2:0] CSR_KNEE_MAX   = 3'd5;

   typedef struct packed {
      logic [15:0] l1;
      logic [15:0] l2;
      logic [7:0]  hip_min;
      logic [7:0]  hip_max;
      logic [7:0]  knee_min;
      logic [7:0]  knee_max;
   } cfg_type;

   typedef struct packed {
      logic signed [12:0] x;
      logic signed [12:0] y;
      logic               zero;
      logic               neg;
      logic [23:0]        nm;
      logic [23:0]        dm;
   } item_type;

   function automatic logic signed [ZW-1:0] atan_entry(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0:  v = 34'sd843314857;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043837;
         3:  v = 34'sd133525159;
         4:  v = 34'sd67021687;
         5:  v = 34'sd33543516;
         6:  v = 34'sd16775851;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194283;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048576;
         11: v = 34'sd524288;
         12: v = 34'sd262144;
         13: v = 34'sd131072;
         14: v = 34'sd65536;
         15: v = 34'sd32768;
         16: v = 34'sd16384;
         17: v = 34'sd8192;
         18: v = 34'sd4096;
         19: v = 34'sd2048;
         20: v = 34'sd1024;
         21: v = 34'sd512;
         22: v = 34'sd256;
         23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/two_link_leg_inverse_kinematics.sv]
// Two-link leg inverse kinematics: foot target in, hip and knee angles out.
// Register stages: front 6, square root 24, vector build 4, CORDIC CORDIC_STAGES + 2,
// output 2. Throughput: one transaction per cycle; the whole pipeline holds while a
// result is stalled.
// Reset: synchronous, clears all valid bits and loads the link and limit registers.
`default_nettype none
module two_link_leg_inverse_kinematics
   import lik_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [12:0] req_target_x,
   input  wire logic signed [12:0] req_target_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_hip_angle,
   output logic [14:0]             rsp_knee_angle,
   output logic [7:0]              rsp_hip_cmd_deg,
   output logic [7:0]              rsp_knee_cmd_deg,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   cfg_type cfg_ff;
   logic    adv;

   logic        fr_valid;
   item_type    fr_item;
   logic [47:0] fr_rad;

   logic        sq_valid;
   item_type    sq_item;
   logic [23:0] sq_root;

   logic                 mx_valid, mx_zero;
   logic signed [CW-1:0] mx_kx, mx_ky, mx_hx, mx_hy;

   logic               hc_valid, hc_zero, kc_valid, kc_zero;
   logic signed [15:0] hc_angle, kc_angle;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.l1       <= 16'd24360;
         cfg_ff.l2       <= 16'd23080;
         cfg_ff.hip_min  <= 8'd0;
         cfg_ff.hip_max  <= 8'd180;
         cfg_ff.knee_min <= 8'd47;
         cfg_ff.knee_max <= 8'd113;
      end else if (csr_write) begin
         case (csr_index)
            CSR_UPPER_LINK: cfg_ff.l1       <= csr_data;
            CSR_LOWER_LINK: cfg_ff.l2       <= csr_data;
            CSR_HIP_MIN:    cfg_ff.hip_min  <= csr_data[7:0];
            CSR_HIP_MAX:    cfg_ff.hip_max  <= csr_data[7:0];
            CSR_KNEE_MIN:   cfg_ff.knee_min <= csr_data[7:0];
            CSR_KNEE_MAX:   cfg_ff.knee_max <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   lik_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_x      (req_target_x),
      .in_y      (req_target_y),
      .cfg       (cfg_ff),
      .out_valid (fr_valid),
      .out_item  (fr_item),
      .out_rad   (fr_rad)
   );

   lik_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_item   (fr_item),
      .in_rad    (fr_rad),
      .out_valid (sq_valid),
      .out_item  (sq_item),
      .out_root  (sq_root)
   );

   lik_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_item   (sq_item),
      .in_root   (sq_root),
      .cfg       (cfg_ff),
      .out_valid (mx_valid),
      .out_zero  (mx_zero),
      .knee_x    (mx_kx),
      .knee_y    (mx_ky),
      .hip_x     (mx_hx),
      .hip_y     (mx_hy)
   );

   lik_cordic u_hip_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mx_valid),
      .in_flag   (mx_zero),
      .in_x      (mx_hx),
      .in_y      (mx_hy),
      .out_valid (hc_valid),
      .out_flag  (hc_zero),
      .out_angle (hc_angle)
   );

   lik_cordic u_knee_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mx_valid),
      .in_flag   (mx_zero),
      .in_x      (mx_kx),
      .in_y      (mx_ky),
      .out_valid (kc_valid),
      .out_flag  (kc_zero),
      .out_angle (kc_angle)
   );

   lik_post u_post (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (hc_valid && kc_valid),
      .in_zero      (hc_zero || kc_zero),
      .in_hip       (hc_angle),
      .in_knee      (kc_angle),
      .cfg          (cfg_ff),
      .out_valid    (rsp_valid),
      .out_hip      (rsp_hip_angle),
      .out_knee     (rsp_knee_angle),
      .out_hip_cmd  (rsp_hip_cmd_deg),
      .out_knee_cmd (rsp_knee_cmd_deg)
   );

endmodule
`default_nettype wire

[rtl/lik_front.sv]
// Front end: squares, cosine ratio numerator and denominator, clamp, normalize and radicand dm^2 - nm^2.
// Six register stages; depends on lik_pkg.
`default_nettype none
module lik_front
   import lik_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic signed [12:0] in_x,
   input  wire logic signed [12:0] in_y,
   input  wire cfg_type            cfg,
   output logic                    out_valid,
   output item_type                out_item,
   output logic [47:0]             out_rad
);

   logic [5:0] v_ff;

   item_type it1_ff, it2_ff, it3_ff, it4_ff, it5_ff, it6_ff;
   item_type it1_in, it2_in, it4_in;

   logic signed [25:0] sqx_in, sqy_in;
   logic [24:0] xx_ff, yy_ff;
   logic [31:0] l1sq_ff, l2sq_ff, l1l2_ff;

   logic [25:0]        sum_in;
   logic signed [43:0] num_raw, den_raw, num_in, den_in, mag_in;
   logic [33:0]        nm2_ff, dm2_ff, nm3_ff, dm3_ff;

   logic [5:0]  pos_in, pos3_ff, sh_in;
   logic [33:0] dmsh_in, nmsh_in;

   logic [47:0] dd5_ff, nn5_ff, rad6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   assign sqx_in = in_x * in_x;
   assign sqy_in = in_y * in_y;

   always_comb begin
      it1_in      = '0;
      it1_in.x    = in_x;
      it1_in.y    = in_y;
      it1_in.zero = (in_x == 13'sd0) && (in_y == 13'sd0);
   end

   assign sum_in  = {1'b0, xx_ff} + {1'b0, yy_ff};
   assign num_raw = $signed({2'b00, sum_in, 16'h0000}) - $signed({12'h000, l1sq_ff})
                    - $signed({12'h000, l2sq_ff});
   assign den_raw = $signed({11'h000, l1l2_ff, 1'b0});

   always_comb begin
      num_in = num_raw;
      den_in = den_raw;
      if (den_raw == 44'sd0) begin
         den_in = 44'sd1;
         num_in = num_raw[43] ? -44'sd1 : 44'sd1;
      end
      if (num_in > den_in) begin
         num_in = den_in;
      end else if (num_in < -den_in) begin
         num_in = -den_in;
      end
      mag_in    = num_in[43] ? -num_in : num_in;
      it2_in     = it1_ff;
      it2_in.neg = num_in[43];
   end

   always_comb begin
      pos_in = '0;
      for (int i = 0; i < 34; i++) begin
         if (dm2_ff[i]) begin
            pos_in = 6'(i);
         end
      end
   end

   always_comb begin
      if (pos3_ff >= 6'd24) begin
         sh_in   = pos3_ff - 6'd23;
         dmsh_in = dm3_ff >> sh_in;
         nmsh_in = nm3_ff >> sh_in;
      end else begin
         sh_in   = 6'd23 - pos3_ff;
         dmsh_in = dm3_ff << sh_in;
         nmsh_in = nm3_ff << sh_in;
      end
      it4_in    = it3_ff;
      it4_in.dm = dmsh_in[23:0];
      it4_in.nm = nmsh_in[23:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it1_ff  <= it1_in;
         xx_ff   <= sqx_in[24:0];
         yy_ff   <= sqy_in[24:0];
         l1sq_ff <= cfg.l1 * cfg.l1;
         l2sq_ff <= cfg.l2 * cfg.l2;
         l1l2_ff <= cfg.l1 * cfg.l2;

         it2_ff  <= it2_in;
         nm2_ff  <= mag_in[33:0];
         dm2_ff  <= den_in[33:0];

         it3_ff  <= it2_ff;
         nm3_ff  <= nm2_ff;
         dm3_ff  <= dm2_ff;
         pos3_ff <= pos_in;

         it4_ff  <= it4_in;

         it5_ff  <= it4_ff;
         dd5_ff  <= it4_ff.dm * it4_ff.dm;
         nn5_ff  <= it4_ff.nm * it4_ff.nm;

         it6_ff  <= it5_ff;
         rad6_ff <= dd5_ff - nn5_ff;
      end
   end

   assign out_valid = v_ff[5];
   assign out_item  = it6_ff;
   assign out_rad   = rad6_ff;

endmodule
`default_nettype wire

[rtl/lik_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Carries the transaction's item alongside; depends on lik_pkg.
`default_nettype none
module lik_sqrt
   import lik_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        adv,
   input  wire logic        in_valid,
   input  wire item_type    in_item,
   input  wire logic [47:0] in_rad,
   output logic             out_valid,
   output item_type         out_item,
   output logic [23:0]      out_root
);

   logic [SQRT_STEPS-1:0] v_ff;
   logic [25:0] rem_ff  [SQRT_STEPS];
   logic [25:0] rem_in  [SQRT_STEPS];
   logic [23:0] root_ff [SQRT_STEPS];
   logic [23:0] root_in [SQRT_STEPS];
   logic [47:0] rad_ff  [SQRT_STEPS];
   logic [47:0] rad_in  [SQRT_STEPS];
   item_type    item_ff [SQRT_STEPS];
   item_type    item_in [SQRT_STEPS];

   always_comb begin
      logic [25:0] src_rem;
      logic [23:0] src_root;
      logic [47:0] src_rad;
      logic [27:0] rem_n, trial;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (k == 0) begin
            src_rem    = '0;
            src_root   = '0;
            src_rad    = in_rad;
            item_in[k] = in_item;
         end else begin
            src_rem    = rem_ff[k-1];
            src_root   = root_ff[k-1];
            src_rad    = rad_ff[k-1];
            item_in[k] = item_ff[k-1];
         end
         rem_n = {src_rem, src_rad[47:46]};
         trial = {2'b00, src_root, 2'b01};
         if (rem_n >= trial) begin
            rem_n      = rem_n - trial;
            root_in[k] = {src_root[22:0], 1'b1};
         end else begin
            root_in[k] = {src_root[22:0], 1'b0};
         end
         rem_in[k] = rem_n[25:0];
         rad_in[k] = {src_rad[45:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[SQRT_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            item_ff[k] <= item_in[k];
         end
      end
   end

   assign out_valid = v_ff[SQRT_STEPS-1];
   assign out_item  = item_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];

endmodule
`default_nettype wire

[rtl/lik_mix.sv]
// Builds the knee vector and the rotated hip vector from the root and the target.
// Four register stages; depends on lik_pkg.
`default_nettype none
module lik_mix
   import lik_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire item_type           in_item,
   input  wire logic [23:0]        in_root,
   input  wire cfg_type            cfg,
   output logic                    out_valid,
   output logic                    out_zero,
   output logic signed [CW-1:0]    knee_x,
   output logic signed [CW-1:0]    knee_y,
   output logic signed [CW-1:0]    hip_x,
   output logic signed [CW-1:0]    hip_y
);

   logic [3:0] v_ff;

   item_type    it1_ff;
   logic [23:0] root1_ff;
   logic [39:0] p1_ff, p2_ff, p3_ff;

   logic signed [12:0] x2_ff, y2_ff;
   logic               zero2_ff;
   logic signed [24:0] kx2_ff;
   logic [23:0]        ky2_ff;
   logic signed [41:0] k1_ff, k2_ff;

   logic signed [54:0] a_in, b_in, c_in, d_in;
   logic signed [54:0] a3_ff, b3_ff, c3_ff, d3_ff;
   logic signed [24:0] kx3_ff;
   logic [23:0]        ky3_ff;
   logic               zero3_ff;

   logic signed [CW-1:0] hx4_ff, hy4_ff, kx4_ff, ky4_ff;
   logic                 zero4_ff;

   assign a_in = y2_ff * k1_ff;
   assign b_in = x2_ff * k2_ff;
   assign c_in = x2_ff * k1_ff;
   assign d_in = y2_ff * k2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it1_ff   <= in_item;
         root1_ff <= in_root;
         p1_ff    <= cfg.l1 * in_item.dm;
         p2_ff    <= cfg.l2 * in_item.nm;
         p3_ff    <= cfg.l2 * in_root;

         x2_ff    <= it1_ff.x;
         y2_ff    <= it1_ff.y;
         zero2_ff <= it1_ff.zero;
         kx2_ff   <= it1_ff.neg ? -$signed({1'b0, it1_ff.nm}) : $signed({1'b0, it1_ff.nm});
         ky2_ff   <= root1_ff;
         k1_ff    <= it1_ff.neg ? $signed({2'b00, p1_ff}) - $signed({2'b00, p2_ff})
                                : $signed({2'b00, p1_ff}) + $signed({2'b00, p2_ff});
         k2_ff    <= $signed({2'b00, p3_ff});

         a3_ff    <= a_in;
         b3_ff    <= b_in;
         c3_ff    <= c_in;
         d3_ff    <= d_in;
         kx3_ff   <= kx2_ff;
         ky3_ff   <= ky2_ff;
         zero3_ff <= zero2_ff;

         hy4_ff   <= CW'(a3_ff) - CW'(b3_ff);
         hx4_ff   <= CW'(c3_ff) + CW'(d3_ff);
         kx4_ff   <= CW'(kx3_ff);
         ky4_ff   <= $signed({{(CW-24){1'b0}}, ky3_ff});
         zero4_ff <= zero3_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign out_zero  = zero4_ff;
   assign knee_x    = kx4_ff;
   assign knee_y    = ky4_ff;
   assign hip_x     = hx4_ff;
   assign hip_y     = hy4_ff;

endmodule
`default_nettype wire

[rtl/lik_cordic.sv]
// Pipelined vectoring CORDIC atan2 with quarter-turn pre-rotation and Q3.13 rounding.
// CORDIC_STAGES + 2 register stages; depends on lik_pkg.
`default_nettype none
module lik_cordic
   import lik_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire logic                 in_flag,
   input  wire logic signed [CW-1:0] in_x,
   input  wire logic signed [CW-1:0] in_y,
   output logic                      out_valid,
   output logic                      out_flag,
   output logic signed [15:0]        out_angle
);

   localparam int N = CORDIC_STAGES + 1;

   logic [N:0] v_ff;
   logic [N:0] flag_ff;
   logic [N-1:0] null_ff;

   logic signed [CW-1:0] x_ff [N];
   logic signed [CW-1:0] x_in [N];
   logic signed [CW-1:0] y_ff [N];
   logic signed [CW-1:0] y_in [N];
   logic signed [ZW-1:0] z_ff [N];
   logic signed [ZW-1:0] z_in [N];

   logic signed [ZW-1:0] zf, mag_in, r_in;
   logic signed [15:0]   angle_ff;

   always_comb begin
      logic signed [CW-1:0] dx, dy;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_in[0] = in_y;
            y_in[0] = -in_x;
            z_in[0] = Q30_PI_HALF;
         end else begin
            x_in[0] = -in_y;
            y_in[0] = in_x;
            z_in[0] = -Q30_PI_HALF;
         end
      end else begin
         x_in[0] = in_x;
         y_in[0] = in_y;
         z_in[0] = '0;
      end
      for (int k = 1; k < N; k++) begin
         dx = y_ff[k-1] >>> (k-1);
         dy = x_ff[k-1] >>> (k-1);
         if (y_ff[k-1] >= 0) begin
            x_in[k] = x_ff[k-1] + dx;
            y_in[k] = y_ff[k-1] - dy;
            z_in[k] = z_ff[k-1] + atan_entry(k-1);
         end else begin
            x_in[k] = x_ff[k-1] - dx;
            y_in[k] = y_ff[k-1] + dy;
            z_in[k] = z_ff[k-1] - atan_entry(k-1);
         end
      end
   end

   assign zf     = z_ff[N-1];
   assign mag_in = zf[ZW-1] ? -zf : zf;

   always_comb begin
      r_in = (mag_in + 34'sd65536) >>> 17;
      if (r_in > ZW'(Q13_PI)) begin
         r_in = ZW'(Q13_PI);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flag_ff <= {flag_ff[N-1:0], in_flag};
         null_ff <= {null_ff[N-2:0], (in_x == '0) && (in_y == '0)};
         for (int k = 0; k < N; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
         if (null_ff[N-1]) begin
            angle_ff <= '0;
         end else if (zf[ZW-1]) begin
            angle_ff <= -r_in[15:0];
         end else begin
            angle_ff <= r_in[15:0];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_flag  = flag_ff[N];
   assign out_angle = angle_ff;

endmodule
`default_nettype wire

[rtl/lik_post.sv]
// Output stages: zero-target override, degree conversion and servo limit clamp.
// Two register stages, the second is the result register; depends on lik_pkg.
`default_nettype none
module lik_post
   import lik_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic               in_zero,
   input  wire logic signed [15:0] in_hip,
   input  wire logic signed [15:0] in_knee,
   input  wire cfg_type            cfg,
   output logic                    out_valid,
   output logic signed [15:0]      out_hip,
   output logic [14:0]             out_knee,
   output logic [7:0]              out_hip_cmd,
   output logic [7:0]              out_knee_cmd
);

   logic [1:0] v_ff;

   logic signed [15:0] hip_in, hip1_ff, hip2_ff;
   logic [14:0]        knee_in, knee1_ff, knee2_ff;
   logic [15:0]        hmag_in;
   logic               hneg1_ff;
   logic [39:0]        hprod1_ff, kprod1_ff;

   logic signed [9:0] hd_in, kd_in, hcl_in, kcl_in;
   logic [7:0]        hcmd2_ff, kcmd2_ff;

   always_comb begin
      hip_in  = in_zero ? 16'sd0 : in_hip;
      knee_in = (in_zero || in_knee < 0) ? 15'd0 : in_knee[14:0];
      hmag_in = hip_in[15] ? 16'(-hip_in) : hip_in;
   end

   always_comb begin
      hd_in = hneg1_ff ? -$signed({2'b00, hprod1_ff[39:32]}) : $signed({2'b00, hprod1_ff[39:32]});
      kd_in = $signed({2'b00, kprod1_ff[39:32]});
      hcl_in = hd_in;
      if (hd_in < $signed({2'b00, cfg.hip_min})) begin
         hcl_in = $signed({2'b00, cfg.hip_min});
      end else if (hd_in > $signed({2'b00, cfg.hip_max})) begin
         hcl_in = $signed({2'b00, cfg.hip_max});
      end
      kcl_in = kd_in;
      if (kd_in < $signed({2'b00, cfg.knee_min})) begin
         kcl_in = $signed({2'b00, cfg.knee_min});
      end else if (kd_in > $signed({2'b00, cfg.knee_max})) begin
         kcl_in = $signed({2'b00, cfg.knee_max});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hip1_ff   <= hip_in;
         knee1_ff  <= knee_in;
         hneg1_ff  <= hip_in[15];
         hprod1_ff <= hmag_in[14:0] * DEG_SCALE;
         kprod1_ff <= knee_in * DEG_SCALE;

         hip2_ff   <= hip1_ff;
         knee2_ff  <= knee1_ff;
         hcmd2_ff  <= hcl_in[7:0];
         kcmd2_ff  <= kcl_in[7:0];
      end
   end

   assign out_valid    = v_ff[1];
   assign out_hip      = hip2_ff;
   assign out_knee     = knee2_ff;
   assign out_hip_cmd  = hcmd2_ff;
   assign out_knee_cmd = kcmd2_ff;

endmodule
`default_nettype wire
